### rtl/rlwq_pkg.sv
// Shared types and constants of the recursive lock with wait queue.
package rlwq_pkg;

  localparam int THREAD_COUNT = 16;
  localparam int ID_W         = 4;
  localparam int PTR_W        = $clog2(THREAD_COUNT);
  localparam int FILL_W       = $clog2(THREAD_COUNT + 1);
  localparam int NEST_W       = 8;
  localparam int NEST_MAX     = 255;
  localparam int STATUS_W     = 3;
  localparam int IN_TDATA_W   = 8;
  localparam int OUT_TDATA_W  = STATUS_W + 1 + ID_W + NEST_W;

  typedef enum logic [0:0] {
    CMD_ACQUIRE = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED    = 3'd0,
    STAT_BLOCKED    = 3'd1,
    STAT_NESTED     = 3'd2,
    STAT_FREED      = 3'd3,
    STAT_NOT_HOLDER = 3'd4,
    STAT_WAITING    = 3'd5,
    STAT_OVERFLOW   = 3'd6
  } status_e;

endpackage

### rtl/rlwq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rlwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/recursive_lock_with_wait_queue.sv
// Recursive lock with a FIFO wait queue; the queue lives in a small RAM.
// An accepted item is registered and executed in S_EXEC once the output slot is free,
// with the queue head read from RAM; no new item is taken before it is executed.
// The input side accepts a new item while a finished result still waits.
// Reset (rst_ni low, async): lock free, no holder, queue empty, no thread waiting.
// Queue RAM contents are not cleared; entries are read only after being written.
module recursive_lock_with_wait_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rlwq_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // [3:0] thread_id
  input  logic                               s_axis_tuser,  // [0] command
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [2:0] status, [3] woke_valid, [7:4] woke_thread, [15:8] nest_count
  output logic [rlwq_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  localparam int PW = rlwq_pkg::PTR_W;
  localparam int FW = rlwq_pkg::FILL_W;
  localparam int NW = rlwq_pkg::NEST_W;
  localparam int IW = rlwq_pkg::ID_W;

  logic state_q, state_d;

  logic                cmd_q;
  logic [IW-1:0]       id_q;

  logic                holder_valid_q, holder_valid_d;
  logic [IW-1:0]       holder_id_q, holder_id_d;
  logic [NW-1:0]       nest_q, nest_d;
  logic [PW-1:0]       head_q, head_d;
  logic [PW-1:0]       tail_q, tail_d;
  logic [FW-1:0]       fill_q, fill_d;
  logic [rlwq_pkg::THREAD_COUNT-1:0] wmap_q, wmap_d;

  logic                out_valid_q, out_valid_d;
  logic [rlwq_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic                ram_we;
  logic [IW-1:0]       ram_rdata;

  logic                slot_free;
  logic                do_exec;
  logic                is_holder;
  rlwq_pkg::status_e   status;
  logic                woke_valid;
  logic [IW-1:0]       woke_id;

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PW'(rlwq_pkg::THREAD_COUNT - 1)) ? '0 : p + 1'b1;
  endfunction

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign slot_free = !out_valid_q || m_axis_tready;
  assign do_exec   = (state_q == S_EXEC) && slot_free;
  assign is_holder = holder_valid_q && (holder_id_q == id_q);

  // Head entry is read every cycle; the read issued while idle is ready in S_EXEC.
  rlwq_ram #(
    .WIDTH(IW),
    .DEPTH(rlwq_pkg::THREAD_COUNT)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (id_q),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    holder_valid_d = holder_valid_q;
    holder_id_d    = holder_id_q;
    nest_d         = nest_q;
    head_d         = head_q;
    tail_d         = tail_q;
    fill_d         = fill_q;
    wmap_d         = wmap_q;
    ram_we         = 1'b0;
    status         = rlwq_pkg::STAT_GRANTED;
    woke_valid     = 1'b0;
    woke_id        = '0;

    if (cmd_q == rlwq_pkg::CMD_ACQUIRE) begin
      if (is_holder) begin
        if (nest_q >= NW'(rlwq_pkg::NEST_MAX)) begin
          status = rlwq_pkg::STAT_OVERFLOW;
        end else begin
          nest_d = nest_q + 1'b1;
        end
      end else if (!holder_valid_q) begin
        holder_valid_d = 1'b1;
        holder_id_d    = id_q;
        nest_d         = NW'(1);
      end else if (wmap_q[id_q] || (fill_q == FW'(rlwq_pkg::THREAD_COUNT))) begin
        status = rlwq_pkg::STAT_WAITING;
      end else begin
        status       = rlwq_pkg::STAT_BLOCKED;
        ram_we       = do_exec;
        tail_d       = ptr_next(tail_q);
        fill_d       = fill_q + 1'b1;
        wmap_d[id_q] = 1'b1;
      end
    end else begin
      if (!is_holder) begin
        status = rlwq_pkg::STAT_NOT_HOLDER;
      end else if (nest_q > NW'(1)) begin
        status = rlwq_pkg::STAT_NESTED;
        nest_d = nest_q - 1'b1;
      end else begin
        status         = rlwq_pkg::STAT_FREED;
        holder_valid_d = 1'b0;
        holder_id_d    = '0;
        nest_d         = '0;
        if (fill_q != '0) begin
          woke_valid        = 1'b1;
          woke_id           = ram_rdata;
          head_d            = ptr_next(head_q);
          fill_d            = fill_q - 1'b1;
          wmap_d[ram_rdata] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (slot_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_data_d  = {nest_d, woke_id, woke_valid, status};
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      holder_valid_q <= 1'b0;
      holder_id_q    <= '0;
      nest_q         <= '0;
      head_q         <= '0;
      tail_q         <= '0;
      fill_q         <= '0;
      wmap_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (do_exec) begin
        holder_valid_q <= holder_valid_d;
        holder_id_q    <= holder_id_d;
        nest_q         <= nest_d;
        head_q         <= head_d;
        tail_q         <= tail_d;
        fill_q         <= fill_d;
        wmap_q         <= wmap_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tuser;
      id_q  <= s_axis_tdata[IW-1:0];
    end
    out_data_q <= out_data_d;
  end

endmodule

### rtl/rlwq_checker.sv
// Port-level checks for the recursive lock, bound to the top level.
module rlwq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [rlwq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [rlwq_pkg::STATUS_W-1:0] st;
  logic                          woke;
  logic [rlwq_pkg::NEST_W-1:0]   nest;

  assign st   = m_axis_tdata[rlwq_pkg::STATUS_W-1:0];
  assign woke = m_axis_tdata[rlwq_pkg::STATUS_W];
  assign nest = m_axis_tdata[rlwq_pkg::OUT_TDATA_W-1 -: rlwq_pkg::NEST_W];

  // Result held until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // One item in flight: no second accept right after one.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("item accepted while previous one still in work");

  // Only a final release wakes a waiter, and it leaves the lock with no count.
  a_woke_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && woke |-> st == rlwq_pkg::STAT_FREED)
    else $error("waiter woken without final release");

  a_free_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && st == rlwq_pkg::STAT_FREED |-> nest == '0)
    else $error("nesting count not zero after final release");

  // Grant, block and nested release all imply a holder exists afterwards.
  a_held_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == rlwq_pkg::STAT_GRANTED || st == rlwq_pkg::STAT_BLOCKED ||
                      st == rlwq_pkg::STAT_NESTED) |-> nest != '0)
    else $error("lock reported held with zero count");

endmodule

bind recursive_lock_with_wait_queue rlwq_checker u_rlwq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
